// ===== rtl/vgrt_pkg.sv =====
// Shared constants, codes and types of the voxel grid ray traversal core.
package vgrt_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned MAX_DISTANCE = 256;
  localparam int unsigned DIR_FRAC     = 15;
  localparam int unsigned ORIGIN_W     = 48;
  localparam int unsigned DIR_W        = 17;
  localparam int unsigned MAG_W        = DIR_FRAC + 1;
  localparam int unsigned NUM_W        = DIR_FRAC + FRAC_BITS + 1;
  localparam int unsigned TN_W         = NUM_W + 1;
  localparam int unsigned DIST_W       = 25;
  localparam int unsigned VOX_W        = 32;
  localparam int unsigned IN_DATA_W    = 200;
  localparam int unsigned OUT_DATA_W   = 224;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [DIST_W-1:0] MAXD_RESET = DIST_W'(524288);
  localparam logic [TN_W-1:0]   MAXD_LIM   = TN_W'(MAX_DISTANCE) << FRAC_BITS;
  localparam logic signed [DIR_W-1:0] DIR_ONE     = DIR_W'(32768);
  localparam logic signed [DIR_W-1:0] DIR_NEG_ONE = -DIR_W'(32768);

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_ANSWER = 1'b1;

  localparam logic REG_MAX_DISTANCE = 1'b0;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_MISS   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_START,
    OP_START_MISS,
    OP_START_REJECT,
    OP_AIR,
    OP_SOLID
  } op_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ip;
    logic [FRAC_BITS-1:0]         frac;
    logic [MAG_W-1:0]             mag;
    logic                         neg;
  } axis_t;

  typedef struct packed {
    op_e          op;
    axis_t [2:0]  ax;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/vgrt_fifo.sv =====
// Small register queue between the classifying front and the stepping back.
module vgrt_fifo #(
  parameter int unsigned DEPTH = vgrt_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vgrt_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vgrt_pkg::entry_t rdata_o
);
  import vgrt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vgrt_front.sv =====
// Input side: takes words, floors the origin and sorts each word into an operation.
module vgrt_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [vgrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             full_i,
  output logic                             push_o,
  output vgrt_pkg::entry_t                 entry_o
);
  import vgrt_pkg::*;

  localparam logic signed [ORIGIN_W-1:0] CMAX = ORIGIN_W'((64'd1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [ORIGIN_W-1:0] CMIN = -CMAX - 1;

  logic signed [ORIGIN_W-1:0] origin [3];
  logic signed [DIR_W-1:0]    dir    [3];
  logic signed [ORIGIN_W-1:0] ip     [3];
  logic signed [DIR_W-1:0]    mag    [3];
  logic                       solid;
  logic                       dir_bad, coord_bad;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign solid         = s_axis_tdata[3*ORIGIN_W + 3*DIR_W];

  always_comb begin
    dir_bad   = 1'b0;
    coord_bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      origin[i] = s_axis_tdata[i*ORIGIN_W +: ORIGIN_W];
      dir[i]    = s_axis_tdata[3*ORIGIN_W + i*DIR_W +: DIR_W];
      ip[i]     = origin[i] >>> FRAC_BITS;
      mag[i]    = (dir[i] < 0) ? -dir[i] : dir[i];
      if (dir[i] > DIR_ONE || dir[i] < DIR_NEG_ONE) dir_bad = 1'b1;
      if (ip[i] > CMAX || ip[i] < CMIN) coord_bad = 1'b1;
      entry_o.ax[i].ip   = ip[i][COORD_BITS-1:0];
      entry_o.ax[i].frac = origin[i][FRAC_BITS-1:0];
      entry_o.ax[i].mag  = mag[i][MAG_W-1:0];
      entry_o.ax[i].neg  = dir[i] < 0;
    end
    priority if (s_axis_tuser == CMD_ANSWER) begin
      entry_o.op = solid ? OP_SOLID : OP_AIR;
    end else if (dir_bad) begin
      entry_o.op = OP_START_MISS;
    end else if (coord_bad) begin
      entry_o.op = OP_START_REJECT;
    end else begin
      entry_o.op = OP_START;
    end
  end

endmodule

// ===== rtl/vgrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vgrt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [vgrt_pkg::NUM_W-1:0]    num_i,
  input  logic [vgrt_pkg::MAG_W-1:0]    den_i,
  output vgrt_pkg::div_stat_t           stat_o,
  output logic [vgrt_pkg::NUM_W-1:0]    quot_o
);
  import vgrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [MAG_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign fits   = trial >= {1'b0, den_q};
  assign quot_o = quo_q;
  assign stat_o = '{busy: busy_q, done: done_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q  <= fits ? MAG_W'(trial - {1'b0, den_q}) : trial[MAG_W-1:0];
        quo_q  <= {quo_q[NUM_W-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/vgrt_back.sv =====
// Ray state, crossing setup through the divider, the stepping walk and the result register.
module vgrt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vgrt_pkg::DIST_W-1:0]   max_distance_i,
  input  logic                          valid_i,
  input  vgrt_pkg::entry_t              entry_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output vgrt_pkg::kind_e               kind_o,
  output logic [vgrt_pkg::VOX_W-1:0]    voxel_o  [3],
  output logic [vgrt_pkg::VOX_W-1:0]    prev_o   [3],
  output logic [1:0]                    normal_axis_o,
  output logic [1:0]                    normal_sign_o,
  output logic [vgrt_pkg::DIST_W-1:0]   distance_o
);
  import vgrt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PICK, ST_STEP} state_e;

  localparam logic signed [COORD_BITS-1:0] CMAX = COORD_BITS'((64'd1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [COORD_BITS-1:0] CMIN = -CMAX - 1;
  localparam logic [1:0] SIGN_POS = 2'b01;
  localparam logic [1:0] SIGN_NEG = 2'b11;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  state_e                       state_q;
  logic [2:0]                   idx_q;
  logic                         div_go_q;
  logic signed [COORD_BITS-1:0] cur_q    [3];
  logic                         neg_q    [3];
  logic                         inf_q    [3];
  logic [FRAC_BITS-1:0]         frac_q   [3];
  logic [MAG_W-1:0]             mag_q    [3];
  logic [TN_W-1:0]              t_next_q [3];
  logic [NUM_W-1:0]             t_step_q [3];
  logic                         active_q;
  logic [TN_W-1:0]              pend_q;
  logic [1:0]                   last_q, pick_q;
  logic                         m_valid_q;
  kind_e                        kind_q;
  logic [VOX_W-1:0]             vox_q    [3];
  logic [VOX_W-1:0]             prv_q    [3];
  logic [1:0]                   naxis_q, nsign_q;
  logic [DIST_W-1:0]            dist_q;

  logic                         out_free, maxd_bad, needs_out;
  logic [1:0]                   div_ax, a_sel;
  logic [NUM_W-1:0]             div_num, div_quot;
  logic [FRAC_BITS:0]           head_room;
  div_stat_t                    div_stat;
  logic                         miss_c, ovf_c;
  logic signed [COORD_BITS-1:0] stepped, hit_prev;

  function automatic logic nearer(input logic inf_a, input logic inf_b,
                                  input logic [TN_W-1:0] tn_a,
                                  input logic [TN_W-1:0] tn_b);
    if (inf_a) return 1'b0;
    if (inf_b) return 1'b1;
    return tn_a < tn_b;
  endfunction

  assign out_free = !m_valid_q || m_ready_i;
  assign maxd_bad = (max_distance_i == '0) || (TN_W'(max_distance_i) > MAXD_LIM);

  always_comb begin
    unique case (entry_i.op)
      OP_START:        needs_out = maxd_bad;
      OP_START_MISS,
      OP_START_REJECT: needs_out = 1'b1;
      OP_SOLID:        needs_out = active_q;
      default:         needs_out = 1'b0;
    endcase
  end

  assign pop_o = (state_q == ST_IDLE) && valid_i && (!needs_out || out_free);

  // even steps give the crossing spacing, odd steps the first crossing
  assign div_ax    = idx_q[2:1];
  assign head_room = (FRAC_BITS+1)'(1) << FRAC_BITS;
  always_comb begin
    if (!idx_q[0]) begin
      div_num = NUM_W'(1) << (DIR_FRAC + FRAC_BITS);
    end else if (neg_q[div_ax]) begin
      div_num = NUM_W'(frac_q[div_ax]) << DIR_FRAC;
    end else begin
      div_num = NUM_W'(head_room - (FRAC_BITS+1)'(frac_q[div_ax])) << DIR_FRAC;
    end
  end

  vgrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num),
    .den_i  (mag_q[div_ax]),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  // ties go to the lower axis
  always_comb begin
    a_sel = AXIS_X;
    if (nearer(inf_q[1], inf_q[0], t_next_q[1], t_next_q[0])) a_sel = AXIS_Y;
    if (nearer(inf_q[2], inf_q[a_sel], t_next_q[2], t_next_q[a_sel])) a_sel = AXIS_Z;
  end

  assign miss_c   = inf_q[pick_q] || (t_next_q[pick_q] > TN_W'(max_distance_i));
  assign ovf_c    = neg_q[pick_q] ? (cur_q[pick_q] <= CMIN) : (cur_q[pick_q] >= CMAX);
  assign stepped  = neg_q[pick_q] ? cur_q[pick_q] - 1'b1 : cur_q[pick_q] + 1'b1;
  assign hit_prev = neg_q[last_q] ? cur_q[last_q] + 1'b1 : cur_q[last_q] - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      div_go_q  <= 1'b0;
      active_q  <= 1'b0;
      pend_q    <= '0;
      last_q    <= AXIS_X;
      pick_q    <= AXIS_X;
      m_valid_q <= 1'b0;
      kind_q    <= KIND_QUERY;
      naxis_q   <= '0;
      nsign_q   <= '0;
      dist_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_q[i]    <= '0;
        neg_q[i]    <= 1'b0;
        inf_q[i]    <= 1'b1;
        frac_q[i]   <= '0;
        mag_q[i]    <= '0;
        t_next_q[i] <= '0;
        t_step_q[i] <= '0;
        vox_q[i]    <= '0;
        prv_q[i]    <= '0;
      end
    end else begin
      div_go_q <= 1'b0;
      if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            unique case (entry_i.op)
              OP_START, OP_START_MISS, OP_START_REJECT: begin
                active_q <= 1'b0;
                if (maxd_bad || entry_i.op != OP_START) begin
                  m_valid_q <= 1'b1;
                  kind_q    <= (!maxd_bad && entry_i.op == OP_START_REJECT) ?
                               KIND_REJECT : KIND_MISS;
                  naxis_q   <= '0;
                  nsign_q   <= '0;
                  dist_q    <= '0;
                  for (int i = 0; i < 3; i++) begin
                    vox_q[i] <= '0;
                    prv_q[i] <= '0;
                  end
                end else begin
                  for (int i = 0; i < 3; i++) begin
                    cur_q[i]  <= entry_i.ax[i].ip;
                    neg_q[i]  <= entry_i.ax[i].neg;
                    inf_q[i]  <= (entry_i.ax[i].mag == '0);
                    frac_q[i] <= entry_i.ax[i].frac;
                    mag_q[i]  <= entry_i.ax[i].mag;
                  end
                  idx_q    <= '0;
                  div_go_q <= 1'b1;
                  state_q  <= ST_DIV;
                end
              end
              OP_AIR: begin
                if (active_q) state_q <= ST_PICK;
              end
              OP_SOLID: begin
                if (active_q) begin
                  active_q  <= 1'b0;
                  m_valid_q <= 1'b1;
                  kind_q    <= KIND_HIT;
                  naxis_q   <= last_q;
                  nsign_q   <= neg_q[last_q] ? SIGN_POS : SIGN_NEG;
                  dist_q    <= pend_q[DIST_W-1:0];
                  for (int i = 0; i < 3; i++) begin
                    vox_q[i] <= VOX_W'(cur_q[i]);
                    prv_q[i] <= (2'(i) == last_q) ? VOX_W'(hit_prev) : VOX_W'(cur_q[i]);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (!idx_q[0]) begin
              t_step_q[div_ax] <= div_quot;
            end else begin
              t_next_q[div_ax] <= TN_W'(div_quot);
            end
            if (idx_q == 3'd5) begin
              state_q <= ST_PICK;
            end else begin
              idx_q    <= idx_q + 1'b1;
              div_go_q <= 1'b1;
            end
          end
        end
        ST_PICK: begin
          pick_q  <= a_sel;
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
            if (miss_c || ovf_c) begin
              active_q <= 1'b0;
              kind_q   <= miss_c ? KIND_MISS : KIND_REJECT;
              naxis_q  <= '0;
              nsign_q  <= '0;
              dist_q   <= '0;
              for (int i = 0; i < 3; i++) begin
                vox_q[i] <= '0;
                prv_q[i] <= '0;
              end
            end else begin
              active_q         <= 1'b1;
              cur_q[pick_q]    <= stepped;
              t_next_q[pick_q] <= t_next_q[pick_q] + TN_W'(t_step_q[pick_q]);
              pend_q           <= t_next_q[pick_q];
              last_q           <= pick_q;
              kind_q           <= KIND_QUERY;
              naxis_q          <= pick_q;
              nsign_q          <= neg_q[pick_q] ? SIGN_POS : SIGN_NEG;
              dist_q           <= t_next_q[pick_q][DIST_W-1:0];
              for (int i = 0; i < 3; i++) begin
                vox_q[i] <= (2'(i) == pick_q) ? VOX_W'(stepped) : VOX_W'(cur_q[i]);
                prv_q[i] <= VOX_W'(cur_q[i]);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_valid_o     = m_valid_q;
  assign kind_o        = kind_q;
  assign voxel_o       = vox_q;
  assign prev_o        = prv_q;
  assign normal_axis_o = naxis_q;
  assign normal_sign_o = nsign_q;
  assign distance_o    = dist_q;

endmodule

// ===== rtl/voxel_grid_ray_traversal_core.sv =====
// Top level of the voxel grid ray traversal core.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata origin, direction, solid; tuser command
//   m_axis    out        m_axis_tvalid/tready       tdata voxel, prev, normal, distance; tuser kind
//   apb       in         psel/penable/pwrite        max_distance at byte address 0
//
// A start word passes through the queue, then six divisions on the one shared divider, then
// the pick and step states. An air answer passes through the queue, the pick and step states
// and the output register; a solid answer through the queue and the output register.
// Reset clears the ray (idle) and sets max_distance to 524288; no clearing pass.
// The input queue takes words while the walk runs; a stalled output holds the walk.
module voxel_grid_ray_traversal_core #(
  parameter int unsigned QUEUE_DEPTH = vgrt_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, solid, zero fill
  input  logic [vgrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // voxel_x/y/z, prev_x/y/z, normal_axis, normal_sign, distance, zero fill
  output logic [vgrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind
  output logic [1:0]                        m_axis_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vgrt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [vgrt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [vgrt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import vgrt_pkg::*;

  logic [DIST_W-1:0] max_distance_q;
  logic              push, full, q_valid, pop;
  entry_t            push_entry, head_entry;
  kind_e             kind;
  logic [VOX_W-1:0]  voxel [3];
  logic [VOX_W-1:0]  prev  [3];
  logic [1:0]        normal_axis, normal_sign;
  logic [DIST_W-1:0] distance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DISTANCE) ? APB_DATA_W'(max_distance_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= MAXD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DISTANCE) begin
      max_distance_q <= pwdata[DIST_W-1:0];
    end
  end

  vgrt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  vgrt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  vgrt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_distance_i (max_distance_q),
    .valid_i        (q_valid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .kind_o         (kind),
    .voxel_o        (voxel),
    .prev_o         (prev),
    .normal_axis_o  (normal_axis),
    .normal_sign_o  (normal_sign),
    .distance_o     (distance)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {3'b000, distance, normal_sign, normal_axis,
                         prev[2], prev[1], prev[0], voxel[2], voxel[1], voxel[0]};

endmodule
